// ----- rtl/nbdse_pkg.sv -----
// shared types, constants and job codes for the nbd server protocol engine
package nbdse_pkg;

  localparam logic [63:0] NbdMagic   = 64'h4e42444d41474943;
  localparam logic [63:0] OptMagic   = 64'h49484156454f5054;
  localparam logic [31:0] ReqMagic   = 32'h25609513;
  localparam logic [31:0] ReplyMagic = 32'h67446698;
  localparam logic [31:0] RepUnsup   = 32'h80000001;
  localparam logic [31:0] RepAck     = 32'h00000001;
  localparam logic [31:0] ErrNotsup  = 32'd95;
  localparam logic [15:0] GreetFlags = 16'h0003;
  localparam logic [15:0] ExpFlags   = 16'h0065;

  localparam int unsigned JobDepth = 4;
  localparam int unsigned OutDepth = 4;

  localparam logic [1:0] ActOpen  = 2'd0;
  localparam logic [1:0] ActByte  = 2'd1;
  localparam logic [1:0] ActClose = 2'd2;

  localparam logic [1:0] CfgExportSize = 2'd0;
  localparam logic [1:0] CfgClientId   = 2'd1;

  localparam logic [1:0] LinkNeg   = 2'd0;
  localparam logic [1:0] LinkXmit  = 2'd1;
  localparam logic [1:0] LinkClean = 2'd2;
  localparam logic [1:0] LinkFault = 2'd3;

  typedef enum logic [2:0] {
    JOB_NONE, JOB_GREET, JOB_EXPORT, JOB_OPTREP, JOB_SIMPLE
  } job_kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tx_word;
    logic [3:0]  tx_count;
    logic        read_go;
    logic [63:0] read_offset;
    logic [31:0] read_length;
    logic [7:0]  read_client;
    logic [1:0]  link_state;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_kind_e   kind;
    logic [1:0]  link;
    logic [63:0] handle;
    logic [31:0] opt;
    logic [31:0] code;
    logic        omit;
    logic        rd_go;
    logic [63:0] rd_off;
    logic [31:0] rd_len;
  } job_t;

endpackage

// ----- rtl/nbdse_fifo.sv -----
// small flop queue with push/full and pop/empty sides
module nbdse_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end
endmodule

// ----- rtl/nbdse_front.sv -----
// byte parser: tracks the protocol phase and emits one reply job per item
module nbdse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  nbdse_pkg::in_item_t item_i,
  output nbdse_pkg::job_t     job_o
);
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhFlags   = 3'd1;
  localparam logic [2:0] PhOptHdr  = 3'd2;
  localparam logic [2:0] PhOptData = 3'd3;
  localparam logic [2:0] PhReq     = 3'd4;
  localparam logic [2:0] PhWData   = 3'd5;
  localparam logic [2:0] PhDone    = 3'd6;
  localparam logic [2:0] PhFault   = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [63:0] magic_q, magic_d;
  logic [31:0] opt_q, opt_d;
  logic [31:0] left_q, left_d;
  logic [15:0] rtype_q, rtype_d;
  logic [63:0] handle_q, handle_d;
  logic [63:0] off_q, off_d;
  logic [31:0] len_q, len_d;
  logic        omit_q, omit_d;
  logic [7:0]  b;
  logic        fin_opt;

  assign b = item_i.rx_byte;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    magic_d  = magic_q;
    opt_d    = opt_q;
    left_d   = left_q;
    rtype_d  = rtype_q;
    handle_d = handle_q;
    off_d    = off_q;
    len_d    = len_q;
    omit_d   = omit_q;
    fin_opt  = 1'b0;
    job_o    = '0;
    job_o.kind = nbdse_pkg::JOB_NONE;

    unique case (item_i.action)
      nbdse_pkg::ActOpen: begin
        idx_d    = '0;
        magic_d  = '0;
        opt_d    = '0;
        left_d   = '0;
        rtype_d  = '0;
        handle_d = '0;
        off_d    = '0;
        len_d    = '0;
        omit_d   = 1'b0;
        phase_d  = PhFlags;
        job_o.kind = nbdse_pkg::JOB_GREET;
      end
      nbdse_pkg::ActByte: begin
        unique case (phase_q)
          PhFlags: begin
            if (idx_q >= 5'd3) begin
              omit_d  = b[1];
              idx_d   = '0;
              phase_d = PhOptHdr;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          PhOptHdr: begin
            if (idx_q < 5'd8) begin
              magic_d = (idx_q == '0) ? {56'd0, b} : {magic_q[55:0], b};
            end else if (idx_q < 5'd12) begin
              opt_d = {opt_q[23:0], b};
            end else begin
              left_d = {left_q[23:0], b};
            end
            if (idx_q >= 5'd15) begin
              idx_d = '0;
              if (magic_d != nbdse_pkg::OptMagic) begin
                phase_d = PhFault;
              end else if (left_d != '0) begin
                phase_d = PhOptData;
              end else begin
                fin_opt = 1'b1;
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          PhOptData: begin
            left_d = left_q - 1'b1;
            if (left_d == '0) begin
              fin_opt = 1'b1;
            end
          end
          PhReq: begin
            if (idx_q < 5'd4) begin
              magic_d = (idx_q == '0) ? {56'd0, b} : {magic_q[55:0], b};
            end else if (idx_q < 5'd6) begin
              magic_d = magic_q;
            end else if (idx_q < 5'd8) begin
              rtype_d = {rtype_q[7:0], b};
            end else if (idx_q < 5'd16) begin
              handle_d = {handle_q[55:0], b};
            end else if (idx_q < 5'd24) begin
              off_d = {off_q[55:0], b};
            end else begin
              len_d = {len_q[23:0], b};
            end
            if (idx_q >= 5'd27) begin
              idx_d = '0;
              if (magic_d[31:0] != nbdse_pkg::ReqMagic) begin
                phase_d = PhFault;
              end else begin
                unique case (rtype_d)
                  16'd0: begin
                    job_o.kind  = nbdse_pkg::JOB_SIMPLE;
                    job_o.rd_go = (len_d != '0);
                  end
                  16'd1: begin
                    if (len_d == '0) begin
                      job_o.kind = nbdse_pkg::JOB_SIMPLE;
                    end else begin
                      left_d  = len_d;
                      phase_d = PhWData;
                    end
                  end
                  16'd2: phase_d = PhDone;
                  16'd3, 16'd4, 16'd6: job_o.kind = nbdse_pkg::JOB_SIMPLE;
                  default: begin
                    job_o.kind = nbdse_pkg::JOB_SIMPLE;
                    job_o.code = nbdse_pkg::ErrNotsup;
                  end
                endcase
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          PhWData: begin
            left_d = left_q - 1'b1;
            if (left_d == '0) begin
              job_o.kind = nbdse_pkg::JOB_SIMPLE;
              phase_d    = PhReq;
              idx_d      = '0;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      nbdse_pkg::ActClose: begin
        if (phase_q >= PhFlags && phase_q <= PhWData) begin
          phase_d = PhDone;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (fin_opt) begin
      idx_d = '0;
      job_o.opt = opt_d;
      if (opt_d == 32'd1) begin
        job_o.kind = nbdse_pkg::JOB_EXPORT;
        phase_d    = PhReq;
      end else if (opt_d == 32'd2) begin
        job_o.kind = nbdse_pkg::JOB_OPTREP;
        job_o.code = nbdse_pkg::RepAck;
        phase_d    = PhDone;
      end else begin
        job_o.kind = nbdse_pkg::JOB_OPTREP;
        job_o.code = nbdse_pkg::RepUnsup;
        phase_d    = PhOptHdr;
      end
    end

    job_o.handle = handle_d;
    job_o.omit   = omit_d;
    job_o.rd_off = off_d;
    job_o.rd_len = len_d;

    unique case (phase_d)
      PhFlags, PhOptHdr, PhOptData: job_o.link = nbdse_pkg::LinkNeg;
      PhReq, PhWData:               job_o.link = nbdse_pkg::LinkXmit;
      PhFault:                      job_o.link = nbdse_pkg::LinkFault;
      default:                      job_o.link = nbdse_pkg::LinkClean;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
      omit_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      omit_q  <= omit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      magic_q  <= magic_d;
      opt_q    <= opt_d;
      left_q   <= left_d;
      rtype_q  <= rtype_d;
      handle_q <= handle_d;
      off_q    <= off_d;
      len_q    <= len_d;
    end
  end
endmodule

// ----- rtl/nbdse_back.sv -----
// reply builder: expands one job into its sequence of 8-byte result words
module nbdse_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  nbdse_pkg::job_t      job_i,
  output logic                 job_pop_o,
  input  logic [63:0]          export_size_i,
  input  logic [7:0]           client_id_i,
  output logic                 out_push_o,
  input  logic                 out_full_i,
  output nbdse_pkg::out_item_t out_o
);
  logic [4:0] k_q, k_d;
  logic [4:0] nwords;
  logic       is_last;
  logic       step;

  always_comb begin
    unique case (job_i.kind)
      nbdse_pkg::JOB_GREET:  nwords = 5'd3;
      nbdse_pkg::JOB_EXPORT: nwords = job_i.omit ? 5'd2 : 5'd17;
      nbdse_pkg::JOB_OPTREP: nwords = 5'd3;
      nbdse_pkg::JOB_SIMPLE: nwords = 5'd2;
      default:               nwords = 5'd1;
    endcase
  end

  assign is_last    = (k_q == nwords - 1'b1);
  assign step       = job_valid_i && !out_full_i;
  assign out_push_o = step;
  assign job_pop_o  = step && is_last;
  assign k_d        = is_last ? '0 : k_q + 1'b1;

  always_comb begin
    out_o            = '0;
    out_o.link_state = job_i.link;
    out_o.last       = is_last;
    unique case (job_i.kind)
      nbdse_pkg::JOB_GREET: begin
        priority if (k_q == 5'd0) begin
          out_o.tx_word = nbdse_pkg::NbdMagic;
          out_o.tx_count = 4'd8;
        end else if (k_q == 5'd1) begin
          out_o.tx_word = nbdse_pkg::OptMagic;
          out_o.tx_count = 4'd8;
        end else begin
          out_o.tx_word = {nbdse_pkg::GreetFlags, 48'd0};
          out_o.tx_count = 4'd2;
        end
      end
      nbdse_pkg::JOB_EXPORT: begin
        priority if (k_q == 5'd0) begin
          out_o.tx_word = export_size_i;
          out_o.tx_count = 4'd8;
        end else if (k_q == 5'd1) begin
          out_o.tx_word = {nbdse_pkg::ExpFlags, 48'd0};
          out_o.tx_count = job_i.omit ? 4'd2 : 4'd8;
        end else if (k_q == 5'd16) begin
          out_o.tx_count = 4'd6;
        end else begin
          out_o.tx_count = 4'd8;
        end
      end
      nbdse_pkg::JOB_OPTREP: begin
        priority if (k_q == 5'd0) begin
          out_o.tx_word = nbdse_pkg::OptMagic;
          out_o.tx_count = 4'd8;
        end else if (k_q == 5'd1) begin
          out_o.tx_word = {job_i.opt, job_i.code};
          out_o.tx_count = 4'd8;
        end else begin
          out_o.tx_count = 4'd4;
        end
      end
      nbdse_pkg::JOB_SIMPLE: begin
        if (k_q == 5'd0) begin
          out_o.tx_word = {nbdse_pkg::ReplyMagic, job_i.code};
        end else begin
          out_o.tx_word = job_i.handle;
          if (job_i.rd_go) begin
            out_o.read_go     = 1'b1;
            out_o.read_offset = job_i.rd_off;
            out_o.read_length = job_i.rd_len;
            out_o.read_client = client_id_i;
          end
        end
        out_o.tx_count = 4'd8;
      end
      default: begin
        out_o.tx_count = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (step) begin
      k_q <= k_d;
    end
  end
endmodule

// ----- rtl/nbd_server_protocol_engine_top.sv -----
// top level of the nbd server protocol engine
// Takes one event item per cycle (connection open, received byte, peer close)
// as long as the job queue between the parser and the reply builder has room.
// Every item yields at least one result word; the reply builder emits one
// 8-byte word per cycle while the output queue has room. The result words
// per item are 1 for a silent byte, 2 for a simple reply, 3 for the
// greeting or an option reply, and 17 for an export reply with padding.
// Bursts are absorbed by the job queue and the output queue.
module nbd_server_protocol_engine_top #(
  parameter int unsigned JobDepth = nbdse_pkg::JobDepth,
  parameter int unsigned OutDepth = nbdse_pkg::OutDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  nbdse_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output nbdse_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);
  logic [63:0]          export_size_q;
  logic [7:0]           client_id_q;
  logic                 take;
  nbdse_pkg::job_t      job_in, job_out;
  logic                 jq_empty, jq_pop;
  logic                 oq_push, oq_full;
  nbdse_pkg::out_item_t word;

  assign take = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      export_size_q <= '0;
      client_id_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == nbdse_pkg::CfgExportSize) begin
        export_size_q <= cfg_data_i;
      end else if (cfg_idx_i == nbdse_pkg::CfgClientId) begin
        client_id_q <= cfg_data_i[7:0];
      end
    end
  end

  nbdse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item_i),
    .job_o  (job_in)
  );

  nbdse_fifo #(
    .Width ($bits(nbdse_pkg::job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (jq_pop),
    .data_o  (job_out),
    .empty_o (jq_empty)
  );

  nbdse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!jq_empty),
    .job_i         (job_out),
    .job_pop_o     (jq_pop),
    .export_size_i (export_size_q),
    .client_id_i   (client_id_q),
    .out_push_o    (oq_push),
    .out_full_i    (oq_full),
    .out_o         (word)
  );

  nbdse_fifo #(
    .Width ($bits(nbdse_pkg::out_item_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (word),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );
endmodule
